@@ design/bst_pkg.sv @@
// Shared types and constants for the byte stream tokenizer.
// Holds the token and record structs, the token kind codes and the queue sizing.
// No dependencies.
`default_nettype none

package bst_pkg;

    // width of the running byte offset counter (8 to 32)
    localparam int OffsetBits = 16;

    // widths of the output fields
    localparam int KindBits  = 4;
    localparam int StartBits = 16;
    localparam int LenBits   = 16;

    // saturation ceiling for token lengths
    localparam logic [LenBits-1:0] LenMax = {LenBits{1'b1}};

    // record queue sizing, depth kept a power of two so pointers wrap freely
    localparam int QueueDepth = 4;
    localparam int QAddrBits  = $clog2(QueueDepth);
    localparam int QCntBits   = $clog2(QueueDepth + 1);

    // token kind codes
    localparam logic [KindBits-1:0] KindIdent     = 4'd0;
    localparam logic [KindBits-1:0] KindNumber    = 4'd1;
    localparam logic [KindBits-1:0] KindArrow     = 4'd2;
    localparam logic [KindBits-1:0] KindMinus     = 4'd3;
    localparam logic [KindBits-1:0] KindColon     = 4'd4;
    localparam logic [KindBits-1:0] KindPlus      = 4'd5;
    localparam logic [KindBits-1:0] KindSemicolon = 4'd6;
    localparam logic [KindBits-1:0] KindLbrace    = 4'd7;
    localparam logic [KindBits-1:0] KindRbrace    = 4'd8;
    localparam logic [KindBits-1:0] KindEquals    = 4'd9;
    localparam logic [KindBits-1:0] KindStar      = 4'd10;
    localparam logic [KindBits-1:0] KindLess      = 4'd11;
    localparam logic [KindBits-1:0] KindGreater   = 4'd12;
    localparam logic [KindBits-1:0] KindQuote     = 4'd13;
    localparam logic [KindBits-1:0] KindEnd       = 4'd14;

    // one emitted token
    typedef struct packed {
        logic [KindBits-1:0]  kind;
        logic [StartBits-1:0] start;
        logic [LenBits-1:0]   len;
    } token_t;

    // all tokens caused by one byte: first always present, second optional
    typedef struct packed {
        token_t first;
        token_t second;
        logic   has_second;
    } rec_t;

    // queue handshake towards the front
    typedef struct packed {
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

@@ design/bst_front.sv @@
// Front end of the tokenizer: accepts bytes, runs the scanner and builds token records.
// Depends on bst_pkg.
`default_nettype none

module bst_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        char_code,
    input  wire bst_pkg::q_status_t q_status,
    output logic                   push,
    output bst_pkg::rec_t          push_rec
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_MINUS
    } mode_t;

    localparam logic [7:0] CharNul     = 8'h00;
    localparam logic [7:0] CharTab     = 8'h09;
    localparam logic [7:0] CharLf      = 8'h0A;
    localparam logic [7:0] CharCr      = 8'h0D;
    localparam logic [7:0] CharSpace   = 8'h20;
    localparam logic [7:0] CharQuote   = 8'h22;
    localparam logic [7:0] CharStar    = 8'h2A;
    localparam logic [7:0] CharPlus    = 8'h2B;
    localparam logic [7:0] CharMinus   = 8'h2D;
    localparam logic [7:0] CharZero    = 8'h30;
    localparam logic [7:0] CharNine    = 8'h39;
    localparam logic [7:0] CharColon   = 8'h3A;
    localparam logic [7:0] CharSemi    = 8'h3B;
    localparam logic [7:0] CharLess    = 8'h3C;
    localparam logic [7:0] CharEquals  = 8'h3D;
    localparam logic [7:0] CharGreater = 8'h3E;
    localparam logic [7:0] CharUpperA  = 8'h41;
    localparam logic [7:0] CharUpperZ  = 8'h5A;
    localparam logic [7:0] CharUnder   = 8'h5F;
    localparam logic [7:0] CharLowerA  = 8'h61;
    localparam logic [7:0] CharLowerZ  = 8'h7A;
    localparam logic [7:0] CharLbrace  = 8'h7B;
    localparam logic [7:0] CharRbrace  = 8'h7D;

    mode_t                            mode_reg, mode_next;
    logic [bst_pkg::OffsetBits-1:0]   begin_reg, begin_next;
    logic [bst_pkg::OffsetBits-1:0]   pos_reg, pos_next;
    logic [bst_pkg::LenBits-1:0]      run_reg, run_next;

    logic                             accept;
    logic                             is_letter, is_digit, is_space;
    logic                             is_symbol;
    logic [bst_pkg::KindBits-1:0]     sym_kind;
    logic [bst_pkg::LenBits-1:0]      run_inc;
    logic                             handled;
    logic                             tok_a_vld, tok_b_vld;
    bst_pkg::token_t                  tok_a, tok_b;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    // byte classes
    assign is_letter = ((char_code >= CharLowerA) && (char_code <= CharLowerZ))
                    || ((char_code >= CharUpperA) && (char_code <= CharUpperZ))
                    || (char_code == CharUnder);
    assign is_digit  = (char_code >= CharZero) && (char_code <= CharNine);
    assign is_space  = (char_code == CharSpace) || (char_code == CharTab)
                    || (char_code == CharLf) || (char_code == CharCr);

    // saturating length increment
    assign run_inc = (run_reg == bst_pkg::LenMax) ? run_reg : run_reg + 1'b1;

    // single character symbol decoder
    always_comb
    begin
        is_symbol = 1'b1;
        sym_kind  = bst_pkg::KindEnd;
        unique case (char_code)
            CharColon:   sym_kind = bst_pkg::KindColon;
            CharPlus:    sym_kind = bst_pkg::KindPlus;
            CharSemi:    sym_kind = bst_pkg::KindSemicolon;
            CharLbrace:  sym_kind = bst_pkg::KindLbrace;
            CharRbrace:  sym_kind = bst_pkg::KindRbrace;
            CharEquals:  sym_kind = bst_pkg::KindEquals;
            CharStar:    sym_kind = bst_pkg::KindStar;
            CharLess:    sym_kind = bst_pkg::KindLess;
            CharGreater: sym_kind = bst_pkg::KindGreater;
            CharQuote:   sym_kind = bst_pkg::KindQuote;
            default:     is_symbol = 1'b0;
        endcase
    end

    // scanner: close a pending token, then handle the byte on its own
    always_comb
    begin
        mode_next  = mode_reg;
        begin_next = begin_reg;
        run_next   = run_reg;
        handled    = 1'b0;
        tok_a_vld  = 1'b0;
        tok_b_vld  = 1'b0;
        tok_a.kind  = bst_pkg::KindIdent;
        tok_a.start = bst_pkg::StartBits'(begin_reg);
        tok_a.len   = run_reg;
        tok_b.kind  = bst_pkg::KindEnd;
        tok_b.start = bst_pkg::StartBits'(pos_reg);
        tok_b.len   = bst_pkg::LenBits'(1);

        unique case (mode_reg)
            MODE_IDENT:
            begin
                if (is_letter || is_digit)
                begin
                    run_next = run_inc;
                    handled  = 1'b1;
                end
                else
                begin
                    tok_a_vld  = 1'b1;
                    tok_a.kind = bst_pkg::KindIdent;
                    mode_next  = MODE_IDLE;
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit)
                begin
                    run_next = run_inc;
                    handled  = 1'b1;
                end
                else
                begin
                    tok_a_vld  = 1'b1;
                    tok_a.kind = bst_pkg::KindNumber;
                    mode_next  = MODE_IDLE;
                end
            end
            MODE_MINUS:
            begin
                mode_next = MODE_IDLE;
                tok_a_vld = 1'b1;
                if (char_code == CharGreater)
                begin
                    tok_a.kind = bst_pkg::KindArrow;
                    tok_a.len  = bst_pkg::LenBits'(2);
                    handled    = 1'b1;
                end
                else
                begin
                    tok_a.kind = bst_pkg::KindMinus;
                    tok_a.len  = bst_pkg::LenBits'(1);
                end
            end
            default:
            begin
            end
        endcase

        if (!handled)
        begin
            if (is_space)
            begin
            end
            else if (is_letter)
            begin
                mode_next  = MODE_IDENT;
                begin_next = pos_reg;
                run_next   = bst_pkg::LenBits'(1);
            end
            else if (is_digit)
            begin
                mode_next  = MODE_NUMBER;
                begin_next = pos_reg;
                run_next   = bst_pkg::LenBits'(1);
            end
            else if (char_code == CharMinus)
            begin
                mode_next  = MODE_MINUS;
                begin_next = pos_reg;
                run_next   = bst_pkg::LenBits'(1);
            end
            else
            begin
                tok_b_vld  = 1'b1;
                tok_b.kind = is_symbol ? sym_kind : bst_pkg::KindEnd;
            end
        end

        // end of input restarts the offset
        if (char_code == CharNul)
        begin
            mode_next  = MODE_IDLE;
            begin_next = '0;
            run_next   = '0;
            pos_next   = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // record towards the queue
    always_comb
    begin
        push                = accept && (tok_a_vld || tok_b_vld);
        push_rec.first      = tok_a_vld ? tok_a : tok_b;
        push_rec.second     = tok_b;
        push_rec.has_second = tok_a_vld && tok_b_vld;
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            begin_reg <= '0;
            pos_reg   <= '0;
            run_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            begin_reg <= begin_next;
            pos_reg   <= pos_next;
            run_reg   <= run_next;
        end
    end

endmodule

`default_nettype wire

@@ design/bst_queue.sv @@
// Short record queue between the tokenizer front and back ends.
// Depends on bst_pkg.
`default_nettype none

module bst_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire bst_pkg::rec_t      push_rec,
    output bst_pkg::q_status_t      q_status,
    input  wire logic               pop,
    output bst_pkg::rec_t           pop_rec,
    output logic                    empty
);

    bst_pkg::rec_t                  entry_reg [bst_pkg::QueueDepth];
    logic [bst_pkg::QAddrBits-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [bst_pkg::QCntBits-1:0]   count_reg, count_next;

    assign q_status.full = (count_reg == bst_pkg::QCntBits'(bst_pkg::QueueDepth));
    assign empty         = (count_reg == '0);
    assign pop_rec       = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

`default_nettype wire

@@ design/bst_back.sv @@
// Back end of the tokenizer: unpacks records into single tokens on the output register.
// Depends on bst_pkg.
`default_nettype none

module bst_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bst_pkg::rec_t                 pop_rec,
    input  wire logic                          empty,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [bst_pkg::KindBits-1:0]       token_kind,
    output logic [bst_pkg::StartBits-1:0]      start_offset,
    output logic [bst_pkg::LenBits-1:0]        token_length,
    output logic                               last_of_run
);

    logic            out_valid_reg;
    logic            pend_vld_reg;
    bst_pkg::token_t out_tok_reg;
    bst_pkg::token_t pend_tok_reg;
    logic            last_reg;
    logic            load_ok;

    // output register free to take the next token
    assign load_ok = !out_valid_reg || !out_stall;
    assign pop     = load_ok && !pend_vld_reg && !empty;

    assign out_valid    = out_valid_reg;
    assign token_kind   = out_tok_reg.kind;
    assign start_offset = out_tok_reg.start;
    assign token_length = out_tok_reg.len;
    assign last_of_run  = last_reg;

    // control: output valid and pending second token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_vld_reg  <= 1'b0;
        end
        else if (load_ok)
        begin
            if (pend_vld_reg)
            begin
                out_valid_reg <= 1'b1;
                pend_vld_reg  <= 1'b0;
            end
            else if (!empty)
            begin
                out_valid_reg <= 1'b1;
                pend_vld_reg  <= pop_rec.has_second;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            if (pend_vld_reg)
            begin
                out_tok_reg <= pend_tok_reg;
                last_reg    <= 1'b1;
            end
            else if (!empty)
            begin
                out_tok_reg  <= pop_rec.first;
                last_reg     <= !pop_rec.has_second;
                pend_tok_reg <= pop_rec.second;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/byte_stream_tokenizer.sv @@
// Top level of the byte stream tokenizer.
// Depends on bst_pkg, bst_front, bst_queue and bst_back.
//
// The tokenizer takes one source byte per cycle and emits tokens (kind, start
// offset, saturating length, last-of-run flag) one per cycle while out_stall is
// low. The scanner in the front end decides each byte combinationally, so a new
// byte is taken every cycle while the record queue (four records) has room; the
// queue fills only when the output side stalls or when bytes produce tokens
// faster than one per cycle. A byte yields at most two tokens, which leave in
// order. A token passes through the record queue and the output register after
// the byte that closes it. Whitespace, and bytes that extend an identifier or
// number, produce no token of their own. A zero byte flushes any pending token,
// emits an end token and restarts the offset at zero.
`default_nettype none

module byte_stream_tokenizer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    char_code,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [bst_pkg::KindBits-1:0]       token_kind,
    output logic [bst_pkg::StartBits-1:0]      start_offset,
    output logic [bst_pkg::LenBits-1:0]        token_length,
    output logic                               last_of_run
);

    bst_pkg::q_status_t q_status;
    logic               push;
    bst_pkg::rec_t      push_rec;
    logic               pop;
    bst_pkg::rec_t      pop_rec;
    logic               empty;

    // scanner
    bst_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .q_status  (q_status),
        .push      (push),
        .push_rec  (push_rec)
    );

    // record queue
    bst_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .q_status (q_status),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .empty    (empty)
    );

    // token output
    bst_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_rec      (pop_rec),
        .empty        (empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire

@@ design/bst_checker.sv @@
// Port-level checks for the byte stream tokenizer, bound to the top level.
// Depends on bst_pkg and byte_stream_tokenizer.
`default_nettype none

module bst_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [bst_pkg::KindBits-1:0]  token_kind,
    input  wire logic [bst_pkg::LenBits-1:0]   token_length,
    input  wire logic                          last_of_run
);

    // a stalled output transaction keeps its valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output valid dropped while stalled");

    // every token covers at least one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_length != '0)
        else $error("zero length token");

    // an arrow always spans two bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == bst_pkg::KindArrow |-> token_length == 16'd2)
        else $error("arrow token with wrong length");

    // minus, symbols and end tokens are one byte long
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind >= bst_pkg::KindMinus && token_kind <= bst_pkg::KindEnd
        |-> token_length == 16'd1)
        else $error("single byte token with wrong length");

    // a byte that closes a pending token and then emits its own cannot end on the first
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("second token of a byte missing");

endmodule

bind byte_stream_tokenizer bst_checker u_bst_checker (.*);

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking bench for byte_stream_tokenizer: directed table, symbol burst, random token text.
// Depends on bst_pkg and the byte_stream_tokenizer RTL; expected tokens come from a local scanner.
`default_nettype none

module tb_top;

    import bst_pkg::*;

    // run limits and stimulus sizing
    localparam int unsigned CycleLimit = 1000000;
    localparam int HoldCycles  = 200;
    localparam int DrainCycles = 20;
    localparam int LongRun     = 40;
    localparam int RandItems   = 420;

    // source bytes with a meaning to the scanner
    localparam logic [7:0] ChNul    = 8'h00;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChSpace  = " ";
    localparam logic [7:0] ChMinus  = "-";
    localparam logic [7:0] ChGt     = ">";
    localparam logic [7:0] ChUnder  = "_";
    localparam logic [7:0] ChZero   = "0";
    localparam logic [7:0] ChNine   = "9";
    localparam logic [7:0] ChLowA   = "a";
    localparam logic [7:0] ChLowZ   = "z";
    localparam logic [7:0] ChUpA    = "A";
    localparam logic [7:0] ChUpZ    = "Z";
    localparam logic [7:0] ChColon  = ":";
    localparam logic [7:0] ChQuote  = "\"";
    localparam logic [7:0] ChHighLo = 8'h80;
    localparam logic [7:0] ChHighHi = 8'hFF;

    // the ten single-byte symbols and the kinds they map to
    localparam logic [7:0] SymChars [10] = '{":", "+", ";", "{", "}", "=", "*", "<", ">", "\""};
    localparam logic [KindBits-1:0] SymKinds [10] = '{KindColon, KindPlus, KindSemicolon,
        KindLbrace, KindRbrace, KindEquals, KindStar, KindLess, KindGreater, KindQuote};
    localparam logic [7:0] WsChars [4] = '{ChSpace, ChTab, ChLf, ChCr};

    typedef enum logic [1:0] {ModeIdle, ModeIdent, ModeNumber, ModeMinus} scan_mode_t;

    typedef struct packed {
        logic [KindBits-1:0]  kind;
        logic [StartBits-1:0] start;
        logic [LenBits-1:0]   len;
        logic                 last;
    } tok_exp_t;

    // one directed byte; typed_n < 0 leaves the expected tokens to the scanner
    typedef struct packed {
        logic [7:0] ch;
        int         typed_n;
        tok_exp_t   t0;
        tok_exp_t   t1;
    } dir_row_t;

    localparam tok_exp_t NoTok = '0;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [7:0]           char_code = 8'h00;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [KindBits-1:0]  token_kind;
    logic [StartBits-1:0] start_offset;
    logic [LenBits-1:0]   token_length;
    logic                 last_of_run;

    // scanner state mirrored from the block
    scan_mode_t            scan_st  = ModeIdle;
    logic [OffsetBits-1:0] tok_start = '0;
    logic [OffsetBits-1:0] next_off  = '0;
    logic [LenBits-1:0]    run_len   = '0;
    tok_exp_t              step_toks [2];
    int                    step_n;

    tok_exp_t    awaited_tokens [$];
    dir_row_t    dir_rows [29];
    int          err_count     = 0;
    int          sent_count    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned cycle_count   = 0;
    logic        hold_req      = 1'b0;
    logic        hold_on       = 1'b0;

    byte_stream_tokenizer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // timeout guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        err_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic bit is_word_lead(input logic [7:0] c);
        return (c >= ChLowA && c <= ChLowZ) || (c >= ChUpA && c <= ChUpZ) || c == ChUnder;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= ChZero && c <= ChNine;
    endfunction

    function automatic void add_token(input logic [KindBits-1:0] kind,
                                      input logic [OffsetBits-1:0] start,
                                      input logic [LenBits-1:0] len);
        step_toks[step_n] = '{kind, StartBits'(start), len, 1'b0};
        step_n++;
    endfunction

    // scanner: advance the mirrored state by one byte and collect the tokens it closes
    function automatic void scan_byte(input logic [7:0] c);
        logic [OffsetBits-1:0] here;
        bit                    handled;
        int                    sym;
        here    = next_off;
        handled = 1'b0;
        sym     = -1;
        step_n  = 0;

        // close or extend the pending token
        case (scan_st)
            ModeIdent:
            begin
                if (is_word_lead(c) || is_digit(c))
                begin
                    run_len = (run_len == LenMax) ? LenMax : run_len + 1'b1;
                    handled = 1'b1;
                end
                else
                begin
                    add_token(KindIdent, tok_start, run_len);
                    scan_st = ModeIdle;
                end
            end
            ModeNumber:
            begin
                if (is_digit(c))
                begin
                    run_len = (run_len == LenMax) ? LenMax : run_len + 1'b1;
                    handled = 1'b1;
                end
                else
                begin
                    add_token(KindNumber, tok_start, run_len);
                    scan_st = ModeIdle;
                end
            end
            ModeMinus:
            begin
                scan_st = ModeIdle;
                if (c == ChGt)
                begin
                    add_token(KindArrow, tok_start, LenBits'(2));
                    handled = 1'b1;
                end
                else
                    add_token(KindMinus, tok_start, LenBits'(1));
            end
            default: ;
        endcase

        // the byte on its own
        if (!handled)
        begin
            for (int i = 0; i < 10; i++)
                if (c == SymChars[i])
                    sym = i;
            if (c == ChSpace || c == ChTab || c == ChLf || c == ChCr)
                ;
            else if (is_word_lead(c) || is_digit(c) || c == ChMinus)
            begin
                if (is_word_lead(c))
                    scan_st = ModeIdent;
                else if (is_digit(c))
                    scan_st = ModeNumber;
                else
                    scan_st = ModeMinus;
                tok_start = here;
                run_len   = LenBits'(1);
            end
            else if (sym >= 0)
                add_token(SymKinds[sym], here, LenBits'(1));
            else
                add_token(KindEnd, here, LenBits'(1));
        end

        // end of input restarts the offset
        if (c == ChNul)
        begin
            scan_st   = ModeIdle;
            tok_start = '0;
            run_len   = '0;
            next_off  = '0;
        end
        else
            next_off = here + 1'b1;

        if (step_n > 0)
            step_toks[step_n-1].last = 1'b1;
    endfunction

    // input side: offer one byte, wait for the transaction, then record what it should cause
    task automatic send_byte(input logic [7:0] b, input int typed_n,
                             input tok_exp_t t0, input tok_exp_t t1);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= b;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        scan_byte(b);
        if (typed_n < 0)
        begin
            for (int i = 0; i < step_n; i++)
                awaited_tokens.push_back(step_toks[i]);
        end
        else
        begin
            if (typed_n > 0)
                awaited_tokens.push_back(t0);
            if (typed_n > 1)
                awaited_tokens.push_back(t1);
        end
        sent_count++;
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_byte(b, -1, NoTok, NoTok);
    endtask

    // sender holds off until every awaited token has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_tokens.size() != 0);
    endtask

    function automatic logic [7:0] word_char(input bit lead);
        int r;
        r = $urandom_range(lead ? 52 : 62);
        if (r < 26)
            return 8'(ChLowA + r);
        else if (r < 52)
            return 8'(ChUpA + r - 26);
        else if (r == 52)
            return ChUnder;
        else
            return 8'(ChZero + r - 53);
    endfunction

    // one random piece of source text, mostly well-formed, some noise
    task automatic send_lexeme();
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 22)
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_plain(word_char(i == 0));
        end
        else if (pick < 37)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_plain(8'($urandom_range(ChZero, ChNine)));
        end
        else if (pick < 45)
        begin
            send_plain(ChMinus);
            send_plain(ChGt);
        end
        else if (pick < 52)
            send_plain(ChMinus);
        else if (pick < 72)
            send_plain(SymChars[$urandom_range(9)]);
        else if (pick < 87)
            send_plain(WsChars[$urandom_range(3)]);
        else if (pick < 95)
            send_plain(8'($urandom_range(255)));
        else
            send_plain(ChNul);
    endtask

    // long receiver hold-off, counted here while the sender keeps offering
    initial
    begin
        @(posedge hold_req);
        hold_on <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_on <= 1'b0;
    end

    // output side: check each accepted transaction, then pick the next stall
    always @(posedge clk)
    begin : token_check
        tok_exp_t want;
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (awaited_tokens.size() == 0)
                flag_mismatch($sformatf("unexpected token kind=%0d start=%0d len=%0d last=%0d",
                    token_kind, start_offset, token_length, last_of_run));
            else
            begin
                want = awaited_tokens.pop_front();
                if (token_kind !== want.kind)
                    flag_mismatch($sformatf("token_kind got %0d want %0d",
                        token_kind, want.kind));
                if (start_offset !== want.start)
                    flag_mismatch($sformatf("start_offset got %0d want %0d",
                        start_offset, want.start));
                if (token_length !== want.len)
                    flag_mismatch($sformatf("token_length got %0d want %0d",
                        token_length, want.len));
                if (last_of_run !== want.last)
                    flag_mismatch($sformatf("last_of_run got %0d want %0d",
                        last_of_run, want.last));
            end
        end
        out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
    end

    // main sequence
    initial
    begin
        int phase_end;

        // directed bytes, offsets counted from reset
        dir_rows = '{
            '{ChUpZ,     0, NoTok, NoTok},
            '{ChUnder,  -1, NoTok, NoTok},
            '{ChNine,   -1, NoTok, NoTok},
            '{ChTab,     1, '{KindIdent, 16'd0, 16'd3, 1'b1}, NoTok},
            '{ChZero,   -1, NoTok, NoTok},
            '{ChNine,   -1, NoTok, NoTok},
            '{ChMinus,  -1, NoTok, NoTok},
            '{ChGt,     -1, NoTok, NoTok},
            '{ChMinus,  -1, NoTok, NoTok},
            '{ChLowZ,   -1, NoTok, NoTok},
            '{ChColon,  -1, NoTok, NoTok},
            '{SymChars[1], -1, NoTok, NoTok},
            '{SymChars[2], -1, NoTok, NoTok},
            '{SymChars[3], -1, NoTok, NoTok},
            '{SymChars[4], -1, NoTok, NoTok},
            '{SymChars[5], -1, NoTok, NoTok},
            '{SymChars[6], -1, NoTok, NoTok},
            '{SymChars[7], -1, NoTok, NoTok},
            '{ChGt,     -1, NoTok, NoTok},
            '{ChQuote,  -1, NoTok, NoTok},
            '{ChSpace,  -1, NoTok, NoTok},
            '{ChCr,     -1, NoTok, NoTok},
            '{ChLf,     -1, NoTok, NoTok},
            '{ChHighLo,  1, '{KindEnd, 16'd23, 16'd1, 1'b1}, NoTok},
            '{ChHighHi,  1, '{KindEnd, 16'd24, 16'd1, 1'b1}, NoTok},
            '{ChUpA,    -1, NoTok, NoTok},
            '{ChNul,     2, '{KindIdent, 16'd25, 16'd1, 1'b0}, '{KindEnd, 16'd26, 16'd1, 1'b1}},
            '{ChMinus,  -1, NoTok, NoTok},
            '{ChNul,     2, '{KindMinus, 16'd0, 16'd1, 1'b0}, '{KindEnd, 16'd1, 16'd1, 1'b1}}
        };

        // reset
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles more rarely than the receiver
        send_idle_pct = 27;
        recv_idle_pct = 71;
        foreach (dir_rows[i])
            send_byte(dir_rows[i].ch, dir_rows[i].typed_n, dir_rows[i].t0, dir_rows[i].t1);
        wait_drained();

        // back-pressure: receiver held off while symbols keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_plain(SymChars[$urandom_range(9)]);
        wait_drained();

        phase_end = sent_count + RandItems / 3;
        while (sent_count < phase_end)
            send_lexeme();
        wait_drained();

        // receiver idles more rarely than the sender
        send_idle_pct = 71;
        recv_idle_pct = 27;
        phase_end = sent_count + RandItems / 3;
        while (sent_count < phase_end)
            send_lexeme();
        wait_drained();

        // no idling; one long identifier streamed at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_plain(word_char(1'b1));
        for (int i = 1; i < LongRun; i++)
            send_plain(word_char(1'b0));
        send_plain(ChSpace);
        phase_end = sent_count + RandItems / 3;
        while (sent_count < phase_end)
            send_lexeme();

        // let the last tokens through
        wait_drained();
        repeat (DrainCycles) @(posedge clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
design/bst_pkg.sv
design/bst_front.sv
design/bst_queue.sv
design/bst_back.sv
design/byte_stream_tokenizer.sv
design/bst_checker.sv
verif/tb_top.sv
